FILE: src/cldp_pkg.sv
// cldp_pkg: shared types and constants for the cell list descriptor parser
// no dependencies; used by the channel interfaces, the parse core and the top level
package cldp_pkg;

	// record sizes in bytes
	localparam int unsigned CELL_REC_BYTES = 10;
	localparam int unsigned SUB_REC_BYTES  = 8;

	// one descriptor byte as it arrives on the input channel
	typedef struct packed {
		logic [7:0] data_byte;
		logic       start_of_descriptor;
	} byte_item_t;

	// one parsed cell or subcell record
	typedef struct packed {
		logic        is_subcell;
		logic [15:0] ident;
		logic [15:0] latitude;
		logic [15:0] longitude;
		logic [11:0] extent_lat;
		logic [11:0] extent_lon;
		logic [7:0]  subcell_bytes;
		logic        last_record;
	} record_t;

endpackage

FILE: src/cldp_byte_if.sv
// cldp_byte_if: valid/ready channel carrying one descriptor byte per item
// depends on cldp_pkg
interface cldp_byte_if;
	import cldp_pkg::*;

	logic       valid;
	logic       ready;
	byte_item_t data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

FILE: src/cldp_rec_if.sv
// cldp_rec_if: valid/ready channel carrying one parsed record per item
// depends on cldp_pkg
interface cldp_rec_if;
	import cldp_pkg::*;

	logic    valid;
	logic    ready;
	record_t data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

FILE: src/cldp_parse.sv
// cldp_parse: descriptor parse state and record assembly, one byte per step
// depends on cldp_pkg
module cldp_parse (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                step,
	input  cldp_pkg::byte_item_t item,
	output logic                emit,
	output cldp_pkg::record_t   rec
);
	import cldp_pkg::*;

	localparam logic [3:0] CELL_LAST = 4'(CELL_REC_BYTES - 1);
	localparam logic [3:0] SUB_LAST  = 4'(SUB_REC_BYTES - 1);
	localparam logic [3:0] HOLD_BYTES = 4'(CELL_REC_BYTES - 1);

	logic [7:0] body_length_q;
	logic [8:0] byte_position_q;
	logic [3:0] record_byte_count_q;
	logic       in_subcells_q;
	logic [8:0] subcell_consumed_q;
	logic [7:0] loop_length_q;
	logic [7:0] record_bytes_q [CELL_REC_BYTES-1];
	logic       parsing_active_q;

	logic [8:0] off;
	logic [8:0] end_off;
	logic       take_length;
	logic       in_body;
	logic       final_byte;
	logic [8:0] sc_next;
	logic       in_sub_next;
	logic [9:0] reach;
	logic [7:0] b;

	// position decode
	always_comb begin
		b           = item.data_byte;
		off         = byte_position_q - 9'd2;
		end_off     = off + 9'd1;
		take_length = parsing_active_q && (byte_position_q == 9'd1);
		in_body     = parsing_active_q && !take_length && (off < {1'b0, body_length_q});
		final_byte  = in_subcells_q ? (record_byte_count_q == SUB_LAST)
		                            : (record_byte_count_q == CELL_LAST);
	end

	// record fields and next loop state for a completed record
	always_comb begin
		sc_next     = subcell_consumed_q + 9'(SUB_REC_BYTES);
		rec         = '0;
		in_sub_next = in_subcells_q;
		if (!in_subcells_q) begin
			rec.is_subcell    = 1'b0;
			rec.ident         = {record_bytes_q[0], record_bytes_q[1]};
			rec.latitude      = {record_bytes_q[2], record_bytes_q[3]};
			rec.longitude     = {record_bytes_q[4], record_bytes_q[5]};
			rec.extent_lat    = {record_bytes_q[6], record_bytes_q[7][7:4]};
			rec.extent_lon    = {record_bytes_q[7][3:0], record_bytes_q[8]};
			rec.subcell_bytes = b;
			in_sub_next       = (b != 8'd0);
		end else begin
			rec.is_subcell    = 1'b1;
			rec.ident         = {8'd0, record_bytes_q[0]};
			rec.latitude      = {record_bytes_q[1], record_bytes_q[2]};
			rec.longitude     = {record_bytes_q[3], record_bytes_q[4]};
			rec.extent_lat    = {record_bytes_q[5], record_bytes_q[6][7:4]};
			rec.extent_lon    = {record_bytes_q[6][3:0], b};
			rec.subcell_bytes = 8'd0;
			in_sub_next       = !(sc_next >= {1'b0, loop_length_q});
		end
		// another whole record must fit inside the declared body
		reach = {1'b0, end_off} + (in_sub_next ? 10'(SUB_REC_BYTES) : 10'(CELL_REC_BYTES));
		rec.last_record = !(reach <= {2'b00, body_length_q});
	end

	assign emit = step && !item.start_of_descriptor && in_body && final_byte;

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			body_length_q       <= '0;
			byte_position_q     <= '0;
			record_byte_count_q <= '0;
			in_subcells_q       <= 1'b0;
			subcell_consumed_q  <= '0;
			loop_length_q       <= '0;
			parsing_active_q    <= 1'b0;
		end else if (step) begin
			if (item.start_of_descriptor) begin
				body_length_q       <= '0;
				byte_position_q     <= 9'd1;
				record_byte_count_q <= '0;
				in_subcells_q       <= 1'b0;
				subcell_consumed_q  <= '0;
				loop_length_q       <= '0;
				parsing_active_q    <= 1'b1;
			end else if (take_length) begin
				body_length_q   <= b;
				byte_position_q <= 9'd2;
			end else if (in_body) begin
				byte_position_q <= byte_position_q + 9'd1;
				if (!final_byte) begin
					record_byte_count_q <= record_byte_count_q + 4'd1;
				end else begin
					record_byte_count_q <= '0;
					in_subcells_q       <= in_sub_next;
					if (!in_subcells_q) begin
						loop_length_q      <= b;
						subcell_consumed_q <= '0;
					end else begin
						subcell_consumed_q <= sc_next;
					end
				end
			end
		end
	end

	// record byte store, no reset needed: every byte is written before it is read
	always_ff @(posedge clk) begin
		if (step && !item.start_of_descriptor && in_body && !final_byte &&
		    record_byte_count_q < HOLD_BYTES) begin
			record_bytes_q[record_byte_count_q] <= b;
		end
	end

	// a subcell record never gathers more than its own length
	a_sub_count: assert property (@(posedge clk) disable iff (!arst_n)
		in_subcells_q |-> record_byte_count_q < 4'(SUB_REC_BYTES))
		else $error("subcell byte count overran");

	// no record before a start byte
	a_emit_active: assert property (@(posedge clk) disable iff (!arst_n)
		emit |-> parsing_active_q && byte_position_q >= 9'd2)
		else $error("record emitted outside a descriptor");

	// a start byte always rewinds to the length byte
	a_restart: assert property (@(posedge clk) disable iff (!arst_n)
		step && item.start_of_descriptor |=> byte_position_q == 9'd1 && !in_subcells_q)
		else $error("start byte did not restart the parser");

	// position never runs past the declared body
	a_pos_bound: assert property (@(posedge clk) disable iff (!arst_n)
		parsing_active_q && byte_position_q != 9'd1 |->
		byte_position_q <= {1'b0, body_length_q} + 9'd2)
		else $error("byte position beyond the body");

endmodule

FILE: src/cell_list_descriptor_parser_core.sv
// cell_list_descriptor_parser_core: top level, input register, parse core, result register
// depends on cldp_pkg, cldp_byte_if, cldp_rec_if and cldp_parse
//
//   channel   direction  item          payload
//   byte_in   sink       one byte      data_byte, start_of_descriptor
//   rec_out   source     one record    is_subcell .. last_record
//
// one byte is taken every cycle while rec_out is not stalled; a record leaves through both stages after its final byte
// the two stages are the input register and the result register, parsing sits between
// a stalled rec_out holds both stages; byte_in still fills an empty input register
// arst_n clears the stage valids and the parse state; no clearing pass is needed
module cell_list_descriptor_parser_core (
	input  logic               clk,
	input  logic               arst_n,
	cldp_byte_if.sink          byte_in,
	cldp_rec_if.source         rec_out
);
	import cldp_pkg::*;

	byte_item_t item_s1;
	logic       vld_s1;
	record_t    rec_s2;
	logic       vld_s2;
	logic       advance;
	logic       step;
	logic       emit;
	record_t    rec;

	// stall control
	assign advance       = !vld_s2 || rec_out.ready;
	assign byte_in.ready = advance || !vld_s1;
	assign step          = vld_s1 && advance;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (byte_in.ready) begin
			vld_s1 <= byte_in.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (byte_in.ready && byte_in.valid) begin
			item_s1 <= byte_in.data;
		end
	end

	cldp_parse u_parse (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (step),
		.item   (item_s1),
		.emit   (emit),
		.rec    (rec)
	);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else if (advance) begin
			vld_s2 <= emit;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			rec_s2 <= rec;
		end
	end

	assign rec_out.valid = vld_s2;
	assign rec_out.data  = rec_s2;

endmodule
